FILE: design/als_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the arc segmenter.
package als_pkg;

  // Angles are radians with 30 fraction bits
  localparam logic signed [63:0] PI_Q      = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q = 64'sd1686629713;
  localparam logic signed [63:0] TWO_PI_Q  = 64'sd6746518852;
  localparam logic signed [63:0] EPS_Q     = 64'sd537;
  localparam logic signed [24:0] INV_GAIN  = 25'sd10188014;
  localparam int unsigned        TOL_W     = 21;

  // Iteration counts (last index of each loop)
  localparam logic [5:0] CNT_CORDIC = 6'd29;
  localparam logic [5:0] CNT_SQRT   = 6'd31;
  localparam logic [5:0] CNT_DIV    = 6'd63;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_VEC1_INIT, OP_VEC2_INIT, OP_VEC_STEP, OP_A0_MUL, OP_R,
    OP_T_WRAP, OP_T_DIR, OP_NUM, OP_SQ_INIT, OP_SQ_STEP, OP_DIVQ_INIT, OP_DIVT_INIT,
    OP_DIV_STEP, OP_SEGS, OP_THETA, OP_ROT_WRAP, OP_ROT_INIT, OP_ROT_STEP,
    OP_UX, OP_UY, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] iter;
  } cmd_t;

  typedef struct packed {
    logic one_seg;
    logic last;
  } stat_t;

  // atan(2^-i) in Q30
  function automatic logic signed [63:0] atan_step(input logic [4:0] i);
    logic signed [63:0] v;
    case (i)
      5'd0: v = 64'sd843314856;
      5'd1: v = 64'sd497837829;
      5'd2: v = 64'sd263043836;
      5'd3: v = 64'sd133525158;
      5'd4: v = 64'sd67021686;
      5'd5: v = 64'sd33543515;
      5'd6: v = 64'sd16775850;
      5'd7: v = 64'sd8388437;
      5'd8: v = 64'sd4194282;
      5'd9: v = 64'sd2097149;
      default: v = (64'sd1 <<< (5'd30 - i)) - 64'sd1;
    endcase
    return v;
  endfunction

endpackage

FILE: design/als_ctrl.sv
// Sequencer for the arc segmenter: steps the datapath through each phase.
module als_ctrl
  import als_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001, S_VEC1I = 24'h000002, S_VEC1  = 24'h000004,
    S_A0    = 24'h000008, S_R     = 24'h000010, S_VEC2I = 24'h000020,
    S_VEC2  = 24'h000040, S_TW    = 24'h000080, S_TD    = 24'h000100,
    S_NUM   = 24'h000200, S_SQI   = 24'h000400, S_SQ    = 24'h000800,
    S_DQI   = 24'h001000, S_DQ    = 24'h002000, S_SEGS  = 24'h004000,
    S_DTI   = 24'h008000, S_DT    = 24'h010000, S_THETA = 24'h020000,
    S_RW    = 24'h040000, S_RI    = 24'h080000, S_ROT   = 24'h100000,
    S_UX    = 24'h200000, S_UY    = 24'h400000, S_EMIT  = 24'h800000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.iter  = cnt_r[4:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_VEC1I;
        end
      end
      S_VEC1I: begin
        cmd.op    = OP_VEC1_INIT;
        cnt_nxt   = '0;
        state_nxt = S_VEC1;
      end
      S_VEC1: begin
        cmd.op = OP_VEC_STEP;
        if (cnt_r == CNT_CORDIC) begin
          cnt_nxt   = '0;
          state_nxt = S_A0;
        end else cnt_nxt = cnt_r + 6'd1;
      end
      S_A0: begin
        cmd.op    = OP_A0_MUL;
        state_nxt = S_R;
      end
      S_R: begin
        cmd.op    = OP_R;
        state_nxt = S_VEC2I;
      end
      S_VEC2I: begin
        cmd.op    = OP_VEC2_INIT;
        cnt_nxt   = '0;
        state_nxt = S_VEC2;
      end
      S_VEC2: begin
        cmd.op = OP_VEC_STEP;
        if (cnt_r == CNT_CORDIC) begin
          cnt_nxt   = '0;
          state_nxt = S_TW;
        end else cnt_nxt = cnt_r + 6'd1;
      end
      S_TW: begin
        cmd.op    = OP_T_WRAP;
        state_nxt = S_TD;
      end
      S_TD: begin
        cmd.op    = OP_T_DIR;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = OP_NUM;
        state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.op    = OP_SQ_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ_STEP;
        if (cnt_r == CNT_SQRT) begin
          cnt_nxt   = '0;
          state_nxt = S_DQI;
        end else cnt_nxt = cnt_r + 6'd1;
      end
      S_DQI: begin
        cmd.op    = OP_DIVQ_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DQ;
      end
      S_DQ: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == CNT_DIV) begin
          cnt_nxt   = '0;
          state_nxt = S_SEGS;
        end else cnt_nxt = cnt_r + 6'd1;
      end
      S_SEGS: begin
        cmd.op    = OP_SEGS;
        state_nxt = S_DTI;
      end
      S_DTI: begin
        // one segment means no intermediate points
        if (stat.one_seg) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_DIVT_INIT;
          cnt_nxt   = '0;
          state_nxt = S_DT;
        end
      end
      S_DT: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == CNT_DIV) begin
          cnt_nxt   = '0;
          state_nxt = S_THETA;
        end else cnt_nxt = cnt_r + 6'd1;
      end
      S_THETA: begin
        cmd.op    = OP_THETA;
        state_nxt = S_RW;
      end
      S_RW: begin
        cmd.op    = OP_ROT_WRAP;
        state_nxt = S_RI;
      end
      S_RI: begin
        cmd.op    = OP_ROT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op = OP_ROT_STEP;
        if (cnt_r == CNT_CORDIC) begin
          cnt_nxt   = '0;
          state_nxt = S_UX;
        end else cnt_nxt = cnt_r + 6'd1;
      end
      S_UX: begin
        cmd.op    = OP_UX;
        state_nxt = S_UY;
      end
      S_UY: begin
        cmd.op    = OP_UY;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = stat.last ? S_IDLE : S_RW;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_VEC1I)
    else $error("request not taken");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && stat.last) |=> state_r == S_IDLE)
    else $error("did not finish after last point");

endmodule

FILE: design/als_dp.sv
// Datapath: shared CORDIC, square root, divider and point output registers.
module als_dp
  import als_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [TOL_W-1:0]   tol,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_height,
  input  logic               in_counter_clockwise,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic               out_last_point,
  output logic               out_valid
);

  localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [63:0] MAX_Q = 64'(MAX_SEGMENTS);

  logic signed [32:0] cx_r, cy_r, x1_r, y1_r, x2_r, y2_r;
  logic signed [31:0] h_r;
  logic               ccw_r;
  logic signed [63:0] cor_x_r, cor_y_r, cor_z_r, a0_r, mul_r;
  logic        [35:0] r_r;
  logic signed [35:0] t_r, theta_r, ang_r, rx_r;
  logic        [63:0] num_r, sq_in_r, sq_n_r, sq_res_r, sq_bit_r;
  logic        [64:0] rem_r;
  logic        [63:0] quo_r, den_r;
  logic               tol0_r, small_r;
  logic [SEG_W-1:0]   segs_r, idx_r;

  // Unscale a CORDIC product: round and drop 28 bits
  function automatic logic signed [35:0] unscale(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + 64'sd134217728) >>> 28;
    return s[35:0];
  endfunction

  // Saturate a sum to the 32-bit coordinate range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] o;
    if (v > 40'sd2147483647) o = 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) o = 32'sh80000000;
    else o = v[31:0];
    return o;
  endfunction

  logic signed [32:0] vsx, vsy;
  logic signed [63:0] vx64, vy64, step_dx, step_dy, atn, dif, dw, t64, tdir;
  logic signed [63:0] zw, zf, rvx, rvy;
  logic signed [39:0] mul_a;
  logic signed [63:0] mul_p;
  logic signed [35:0] at;
  logic        [36:0] two_r;
  logic signed [37:0] rdiff;
  logic        [63:0] sq_t, q_pre;
  logic        [64:0] div_sh;

  always_comb begin
    // vector selection for the angle measurements
    vsx  = (cmd.op == OP_VEC2_INIT) ? x2_r : x1_r;
    vsy  = (cmd.op == OP_VEC2_INIT) ? y2_r : y1_r;
    vx64 = 64'(vsx) <<< 24;
    vy64 = 64'(vsy) <<< 24;
    // one CORDIC micro-rotation
    step_dx = cor_y_r >>> cmd.iter;
    step_dy = cor_x_r >>> cmd.iter;
    atn     = atan_step(cmd.iter);
    // travel wrap into (-pi, pi]
    dif = cor_z_r - a0_r;
    if (dif > PI_Q) dw = dif - TWO_PI_Q;
    else if (dif <= -PI_Q) dw = dif + TWO_PI_Q;
    else dw = dif;
    // requested direction
    t64 = 64'(t_r);
    if (!ccw_r) tdir = (t64 >= -EPS_Q) ? t64 - TWO_PI_Q : t64;
    else tdir = (t64 <= EPS_Q) ? t64 + TWO_PI_Q : t64;
    at    = (t_r < 0) ? -t_r : t_r;
    two_r = {r_r, 1'b0};
    rdiff = $signed({1'b0, two_r}) - $signed({17'd0, tol});
    // square root trial
    sq_t = sq_res_r + sq_bit_r;
    // divider trial
    div_sh = {rem_r[63:0], quo_r[63]};
    // rotation angle wrap
    zw = 64'(ang_r);
    if (zw > PI_Q) zw = zw - TWO_PI_Q;
    if (zw > PI_Q) zw = zw - TWO_PI_Q;
    if (zw <= -PI_Q) zw = zw + TWO_PI_Q;
    if (zw <= -PI_Q) zw = zw + TWO_PI_Q;
    // half-turn fold
    rvx = 64'(x1_r);
    rvy = 64'(y1_r);
    zf  = cor_z_r;
    if (cor_z_r > HALF_PI_Q) begin
      rvx = -rvx; rvy = -rvy; zf = cor_z_r - PI_Q;
    end else if (cor_z_r < -HALF_PI_Q) begin
      rvx = -rvx; rvy = -rvy; zf = cor_z_r + PI_Q;
    end
    // segment count selection
    if (tol0_r) q_pre = (num_r == 64'd0) ? 64'd0 : MAX_Q;
    else if (small_r) q_pre = 64'd0;
    else q_pre = quo_r;
    if (q_pre == 64'd0) q_pre = 64'd1;
    if (q_pre > MAX_Q) q_pre = MAX_Q;
    // gain multiplier operand
    mul_a = (cmd.op == OP_UY) ? 40'(cor_y_r >>> 20) : 40'(cor_x_r >>> 20);
    mul_p = mul_a * INV_GAIN;
  end

  assign stat.one_seg = (segs_r <= SEG_W'(1));
  assign stat.last    = (idx_r == segs_r - SEG_W'(1));

  // Datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cx_r  <= 33'(in_center_x);
        cy_r  <= 33'(in_center_y);
        x1_r  <= 33'(in_start_x) - 33'(in_center_x);
        y1_r  <= 33'(in_start_y) - 33'(in_center_y);
        x2_r  <= 33'(in_end_x) - 33'(in_center_x);
        y2_r  <= 33'(in_end_y) - 33'(in_center_y);
        h_r   <= in_height;
        ccw_r <= in_counter_clockwise;
      end
      OP_VEC1_INIT, OP_VEC2_INIT: begin
        if (vx64 < 0) begin
          cor_x_r <= -vx64;
          cor_y_r <= -vy64;
          cor_z_r <= (vy64 >= 0) ? PI_Q : -PI_Q;
        end else begin
          cor_x_r <= vx64;
          cor_y_r <= vy64;
          cor_z_r <= '0;
        end
      end
      OP_VEC_STEP, OP_ROT_STEP: begin
        if (cmd.op == OP_VEC_STEP) begin
          // vectoring: drive y toward zero
          if (cor_y_r >= 0) begin
            cor_x_r <= cor_x_r + step_dx;
            cor_y_r <= cor_y_r - step_dy;
            cor_z_r <= cor_z_r + atn;
          end else begin
            cor_x_r <= cor_x_r - step_dx;
            cor_y_r <= cor_y_r + step_dy;
            cor_z_r <= cor_z_r - atn;
          end
        end else begin
          // rotation: drive z toward zero
          if (cor_z_r >= 0) begin
            cor_x_r <= cor_x_r - step_dx;
            cor_y_r <= cor_y_r + step_dy;
            cor_z_r <= cor_z_r - atn;
          end else begin
            cor_x_r <= cor_x_r + step_dx;
            cor_y_r <= cor_y_r - step_dy;
            cor_z_r <= cor_z_r + atn;
          end
        end
      end
      OP_A0_MUL: begin
        a0_r  <= cor_z_r;
        mul_r <= mul_p;
      end
      OP_R: r_r <= unscale(mul_r);
      OP_T_WRAP: begin
        if ((x1_r == 0 && y1_r == 0) || (x2_r == 0 && y2_r == 0)) t_r <= '0;
        else t_r <= dw[35:0];
      end
      OP_T_DIR: t_r <= tdir[35:0];
      OP_NUM: begin
        num_r   <= 64'(at[35:10]) * 64'(r_r);
        sq_in_r <= 64'(tol) * 64'(rdiff[36:0]);
        tol0_r  <= (tol == '0);
        small_r <= (two_r <= 37'(tol));
      end
      OP_SQ_INIT: begin
        sq_n_r   <= sq_in_r;
        sq_res_r <= '0;
        sq_bit_r <= 64'd1 << 62;
      end
      OP_SQ_STEP: begin
        if (sq_n_r >= sq_t) begin
          sq_n_r   <= sq_n_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_DIVQ_INIT: begin
        rem_r <= '0;
        quo_r <= num_r;
        den_r <= {sq_res_r[42:0], 21'd0};
      end
      OP_DIVT_INIT: begin
        rem_r <= '0;
        quo_r <= 64'(at);
        den_r <= 64'(segs_r);
      end
      OP_DIV_STEP: begin
        if (div_sh >= {1'b0, den_r}) begin
          rem_r <= div_sh - {1'b0, den_r};
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= div_sh;
          quo_r <= {quo_r[62:0], 1'b0};
        end
      end
      OP_SEGS: segs_r <= q_pre[SEG_W-1:0];
      OP_THETA: begin
        theta_r <= (t_r < 0) ? -quo_r[35:0] : quo_r[35:0];
        ang_r   <= (t_r < 0) ? -quo_r[35:0] : quo_r[35:0];
        idx_r   <= SEG_W'(1);
      end
      OP_ROT_WRAP: cor_z_r <= zw;
      OP_ROT_INIT: begin
        cor_x_r <= rvx <<< 24;
        cor_y_r <= rvy <<< 24;
        cor_z_r <= zf;
      end
      OP_UX: mul_r <= mul_p;
      OP_UY: begin
        rx_r  <= unscale(mul_r);
        mul_r <= mul_p;
      end
      OP_EMIT: begin
        out_point_x    <= sat32(40'(cx_r) + 40'(rx_r));
        out_point_y    <= sat32(40'(cy_r) + 40'(unscale(mul_r)));
        out_point_z    <= h_r;
        out_last_point <= stat.last;
        ang_r          <= ang_r + theta_r;
        idx_r          <= idx_r + SEG_W'(1);
      end
      default: ;
    endcase
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= (cmd.op == OP_EMIT);
  end

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_point) |=> !out_valid)
    else $error("point strobe right after last point");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |=> out_valid)
    else $error("emitted point missing");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (idx_r < segs_r))
    else $error("point index past segment count");

endmodule

FILE: design/arc_to_line_segments_top.sv
// Per arc: two 30-step CORDIC vectorings, a 32-step square root and a 64-step division
// set up the segment count; unless there is a single segment, a second 64-step division
// gives the step angle and each intermediate point then takes one 30-step CORDIC rotation.
// busy stays high until the last point; a new arc is taken only when idle.
// Results cannot be stalled; each point is strobed by out_valid for one cycle.
// Reset (rst_n low, synchronous) returns to idle and sets chord_tolerance to 0.1.
module arc_to_line_segments_top
  import als_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_height,
  input  logic               in_counter_clockwise,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic               out_last_point,
  output logic               out_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TOL_W-1:0]   cfg_chord_tolerance
);

  localparam logic [63:0] TOL_RST_FULL = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [TOL_W-1:0] TOL_RST = TOL_RST_FULL[TOL_W-1:0];

  logic [TOL_W-1:0] tol_r;
  cmd_t             cmd;
  stat_t            stat;

  // Tolerance register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_RST;
    else if (cfg_valid && cfg_ready) tol_r <= cfg_chord_tolerance;
  end

  als_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  als_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .tol                  (tol_r),
    .in_center_x          (in_center_x),
    .in_center_y          (in_center_y),
    .in_start_x           (in_start_x),
    .in_start_y           (in_start_y),
    .in_end_x             (in_end_x),
    .in_end_y             (in_end_y),
    .in_height            (in_height),
    .in_counter_clockwise (in_counter_clockwise),
    .out_point_x          (out_point_x),
    .out_point_y          (out_point_y),
    .out_point_z          (out_point_z),
    .out_last_point       (out_last_point),
    .out_valid            (out_valid)
  );

endmodule

FILE: tb/sv/arc_to_line_segments_top_tb.sv
// Self-checking testbench for the arc-to-line-segments block.
module arc_to_line_segments_top_tb
  import als_pkg::*;
();

  localparam longint PRESCALE_Q = 64'sd1 <<< 24;
  localparam longint GAIN_INV = 64'sd10188014;
  localparam int SEG_LIMIT = 64;
  localparam int SETUP_CYCLES = 300;
  localparam longint ATAN_TBL [10] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149};

  typedef struct {
    logic signed [31:0] cx, cy, sx, sy, ex, ey, hz;
    logic ccw;
  } arc_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic last;
  } point_t;

  // Arc segmenter predictor and pending point store
  class arc_scoreboard;
    point_t pending_points[$];
    longint tol;
    int errors;

    function new();
      tol = 6554;
      errors = 0;
    endfunction

    function longint atan_of(int i);
      if (i < 10) return ATAN_TBL[i];
      return (64'sd1 <<< (30 - i)) - 1;
    endfunction

    function longint drop_gain(longint v);
      return (((v >>> 20) * GAIN_INV) + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function longint int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function void vec_angle(longint vx, longint vy, output longint ang, output longint mag);
      longint x, y, z, dx, dy;
      x = vx * PRESCALE_Q;
      y = vy * PRESCALE_Q;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_Q : -PI_Q;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_of(i);
        end else begin
          x -= dx; y += dy; z -= atan_of(i);
        end
      end
      ang = z;
      mag = drop_gain(x);
    endfunction

    function void rot_vec(longint vx, longint vy, longint a, output longint ox,
                          output longint oy);
      longint x, y, z, dx, dy;
      z = a;
      if (z > PI_Q) z -= TWO_PI_Q;
      if (z > PI_Q) z -= TWO_PI_Q;
      if (z <= -PI_Q) z += TWO_PI_Q;
      if (z <= -PI_Q) z += TWO_PI_Q;
      if (z > HALF_PI_Q) begin
        vx = -vx; vy = -vy; z -= PI_Q;
      end else if (z < -HALF_PI_Q) begin
        vx = -vx; vy = -vy; z += PI_Q;
      end
      x = vx * PRESCALE_Q;
      y = vy * PRESCALE_Q;
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_of(i);
        end else begin
          x += dx; y -= dy; z += atan_of(i);
        end
      end
      ox = drop_gain(x);
      oy = drop_gain(y);
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Work out every intermediate point of an accepted arc
    function void note_request(arc_t a);
      longint cx, cy, x1, y1, x2, y2, a0, a2, r, m2, t, at, theta, segs, rx, ry, d;
      longint unsigned num, q;
      point_t p;
      cx = a.cx; cy = a.cy;
      x1 = longint'(a.sx) - cx; y1 = longint'(a.sy) - cy;
      x2 = longint'(a.ex) - cx; y2 = longint'(a.ey) - cy;
      vec_angle(x1, y1, a0, r);
      vec_angle(x2, y2, a2, m2);
      if ((x1 == 0 && y1 == 0) || (x2 == 0 && y2 == 0)) begin
        t = 0;
      end else begin
        t = a2 - a0;
        if (t > PI_Q) t -= TWO_PI_Q;
        else if (t <= -PI_Q) t += TWO_PI_Q;
      end
      // against the direction or near zero: add a full turn in the requested direction
      if (!a.ccw) begin
        if (t >= -EPS_Q) t -= TWO_PI_Q;
      end else begin
        if (t <= EPS_Q) t += TWO_PI_Q;
      end
      at = (t < 0) ? -t : t;
      num = longint'(unsigned'(at >>> 10)) * longint'(unsigned'(r));
      if (tol == 0) begin
        q = (num == 0) ? 0 : SEG_LIMIT;
      end else if (2 * r <= tol) begin
        q = 0;
      end else begin
        d = int_sqrt(tol * (2 * r - tol));
        q = num / (longint'(unsigned'(d)) << 21);
      end
      if (q == 0) q = 1;
      if (q > SEG_LIMIT) q = SEG_LIMIT;
      segs = q;
      theta = t / segs;
      for (longint i = 1; i < segs; i++) begin
        rot_vec(x1, y1, theta * i, rx, ry);
        p.x = clamp32(cx + rx);
        p.y = clamp32(cy + ry);
        p.z = a.hz;
        p.last = (i == segs - 1);
        pending_points.insert(pending_points.size(), p);
      end
    endfunction

    function void check_point(point_t got);
      point_t exp_p;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d z=%0d last=%0b", $realtime,
                 got.x, got.y, got.z, got.last);
        errors++;
        return;
      end
      exp_p = pending_points.pop_front();
      if (got.x !== exp_p.x) begin
        $display("%0t: point_x expected %0d actual %0d", $realtime, exp_p.x, got.x);
        errors++;
      end
      if (got.y !== exp_p.y) begin
        $display("%0t: point_y expected %0d actual %0d", $realtime, exp_p.y, got.y);
        errors++;
      end
      if (got.z !== exp_p.z) begin
        $display("%0t: point_z expected %0d actual %0d", $realtime, exp_p.z, got.z);
        errors++;
      end
      if (got.last !== exp_p.last) begin
        $display("%0t: last_point expected %0b actual %0b", $realtime, exp_p.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, cfg_valid, cfg_ready;
  logic signed [31:0] in_center_x, in_center_y, in_start_x, in_start_y;
  logic signed [31:0] in_end_x, in_end_y, in_height;
  logic in_counter_clockwise;
  logic signed [31:0] out_point_x, out_point_y, out_point_z;
  logic out_last_point, out_valid;
  logic [TOL_W-1:0] cfg_chord_tolerance;

  arc_scoreboard sb;
  int idle_pct;

  arc_to_line_segments_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_height(in_height),
    .in_counter_clockwise(in_counter_clockwise),
    .out_point_x(out_point_x), .out_point_y(out_point_y), .out_point_z(out_point_z),
    .out_last_point(out_last_point), .out_valid(out_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_chord_tolerance(cfg_chord_tolerance)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Monitor: accepted requests and strobed points
  always @(posedge clk) begin
    arc_t a;
    point_t p;
    if (rst_n) begin
      if (start && !busy) begin
        a.cx = in_center_x; a.cy = in_center_y;
        a.sx = in_start_x; a.sy = in_start_y;
        a.ex = in_end_x; a.ey = in_end_y;
        a.hz = in_height; a.ccw = in_counter_clockwise;
        sb.note_request(a);
      end
      if (out_valid) begin
        p.x = out_point_x; p.y = out_point_y; p.z = out_point_z; p.last = out_last_point;
        sb.check_point(p);
      end
    end
  end

  // Drive one arc request, with an optional random gap ahead of it
  task automatic send_arc(arc_t a);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start <= 1'b1;
    in_center_x <= a.cx; in_center_y <= a.cy;
    in_start_x <= a.sx; in_start_y <= a.sy;
    in_end_x <= a.ex; in_end_y <= a.ey;
    in_height <= a.hz; in_counter_clockwise <= a.ccw;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_points.size() != 0 || busy) @(posedge clk);
    repeat (SETUP_CYCLES) @(posedge clk);
  endtask

  task automatic write_tol(logic [TOL_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_chord_tolerance <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.tol = longint'(v);
    cfg_valid <= 1'b0;
  endtask

  function automatic arc_t mk(int cx, int cy, int sx, int sy, int ex, int ey, int hz, bit ccw);
    arc_t a;
    a.cx = cx; a.cy = cy; a.sx = sx; a.sy = sy; a.ex = ex; a.ey = ey; a.hz = hz; a.ccw = ccw;
    return a;
  endfunction

  // Offset with a random magnitude of up to 2^30
  function automatic int rand_off();
    int k;
    k = $urandom_range(0, 30);
    return int'($urandom) >>> (31 - k);
  endfunction

  function automatic arc_t rand_arc();
    arc_t a;
    if ($urandom_range(0, 9) == 0) begin
      a = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             1'($urandom));
    end else begin
      a.cx = int'($urandom) >>> 2;
      a.cy = int'($urandom) >>> 2;
      a.sx = a.cx + rand_off();
      a.sy = a.cy + rand_off();
      if ($urandom_range(0, 4) == 0) begin
        a.ex = a.sx; a.ey = a.sy;
      end else begin
        a.ex = a.cx + rand_off();
        a.ey = a.cy + rand_off();
      end
      a.hz = $urandom;
      a.ccw = 1'($urandom);
    end
    return a;
  endfunction

  localparam int ONE = 65536;

  initial begin
    logic [TOL_W-1:0] phase_tol [4];
    int phase_idle [4];
    sb = new();
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_chord_tolerance = '0;
    in_center_x = 0; in_center_y = 0; in_start_x = 0; in_start_y = 0;
    in_end_x = 0; in_end_y = 0; in_height = 0; in_counter_clockwise = 1'b0;
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed arcs under the reset tolerance
    send_arc(mk(0, 0, ONE, 0, ONE, 0, 32'sh7FFFFFFF, 1));       // full circle ccw
    send_arc(mk(0, 0, ONE, 0, ONE, 0, 32'sh80000000, 0));       // full circle cw
    send_arc(mk(5 * ONE, 3 * ONE, 5 * ONE, 3 * ONE, 9 * ONE, 3 * ONE, 7, 1)); // start at center
    send_arc(mk(ONE, ONE, 9 * ONE, ONE, ONE, ONE, -7, 0));      // end at center
    send_arc(mk(0, 0, 4 * ONE, 0, 0, 4 * ONE, 1, 1));           // quarter ccw
    send_arc(mk(0, 0, 4 * ONE, 0, 0, 4 * ONE, 2, 0));           // three quarters cw
    send_arc(mk(0, 0, 3 * ONE, 0, -3 * ONE, 0, 3, 1));          // half turn
    send_arc(mk(0, 0, 3 * ONE, 0, -3 * ONE, 0, 4, 0));
    send_arc(mk(0, 0, 3 * ONE, 0, 3 * ONE, 1, 5, 1));           // tiny travel
    send_arc(mk(0, 0, 3 * ONE, 1, 3 * ONE, 0, 5, 1));
    send_arc(mk(100, 100, 101, 100, 100, 101, 6, 1));          // radius under tolerance
    send_arc(mk(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1)); // saturating points
    send_arc(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0));
    send_arc(mk(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh80000000, -1, 1));
    send_arc(mk(0, 0, -ONE, -ONE, -ONE, ONE, 0, 0));

    phase_tol = '{21'd6554, 21'd1, 21'd1048576, 21'd0};
    phase_idle = '{0, 67, 0, 6};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_tol((ph == 3) ? TOL_W'($urandom_range(1, 1048576)) : phase_tol[ph]);
      idle_pct = phase_idle[ph];
      for (int n = 0; n < 22; n++) send_arc(rand_arc());
    end

    drain();
    if (sb.errors == 0 && sb.pending_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: arc_to_line_segments_top.f
design/als_pkg.sv
design/als_ctrl.sv
design/als_dp.sv
design/arc_to_line_segments_top.sv
tb/sv/arc_to_line_segments_top_tb.sv
